### hdl/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg: shared constants and types for the keyed LRU cache
// Sizes of the slot array, key and handle widths, and the lookup summary that
// passes from the lookup logic to the slot state in the top level.
// ----------------------------------------------------------------------------
package lkc_pkg;

  // Array geometry and field widths
  localparam int ENTRIES     = 16;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 32;
  localparam int CFG_BITS    = 5;

  // Derived widths: slot index / age rank, and a count that can hold ENTRIES
  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(ENTRIES + 1);

  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  // Outcome of one lookup pass over all slots
  typedef struct packed {
    logic hit;        // key found in a valid slot
    idx_t hit_idx;    // slot holding the key
    idx_t hit_rank;   // age rank of that slot
    logic evict;      // cache is at its limit, a miss replaces the LRU slot
    idx_t target_idx; // slot written on a miss
  } lookup_t;

endpackage

### hdl/lkc_lookup.sv
// ----------------------------------------------------------------------------
// lkc_lookup: parallel tag match and replacement choice
// Compares the request key against every valid slot, picks the first free
// slot, and finds the least recent valid slot by its age rank.
// ----------------------------------------------------------------------------
module lkc_lookup
  import lkc_pkg::*;
(
  input  key_t             key_i,
  input  key_t             slot_key_i   [ENTRIES],
  input  logic [ENTRIES-1:0] slot_valid_i,
  input  idx_t             slot_rank_i  [ENTRIES],
  input  cnt_t             occ_i,
  input  cnt_t             limit_i,
  output lookup_t          lookup_o
);

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] lru;
  idx_t               lru_rank;
  idx_t               hit_idx;
  idx_t               free_idx;
  idx_t               lru_idx;
  logic               evict;

  // The oldest valid slot carries rank occupancy - 1
  assign lru_rank = idx_t'(occ_i - cnt_t'(1));
  assign evict    = (occ_i >= limit_i);

  // Match and LRU flags per slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = slot_valid_i[i] && (slot_key_i[i] == key_i);
      lru[i]   = slot_valid_i[i] && (slot_rank_i[i] == lru_rank);
    end
  end

  // Encode lowest matching, lowest free and LRU slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = idx_t'(i);
      end
      if (!slot_valid_i[i]) begin
        free_idx = idx_t'(i);
      end
      if (lru[i]) begin
        lru_idx = idx_t'(i);
      end
    end
  end

  // Pack the summary
  always_comb begin
    lookup_o.hit        = |match;
    lookup_o.hit_idx    = hit_idx;
    lookup_o.hit_rank   = slot_rank_i[hit_idx];
    lookup_o.evict      = evict;
    lookup_o.target_idx = evict ? lru_idx : free_idx;
  end

endmodule

### hdl/lru_keyed_cache_top.sv
// ----------------------------------------------------------------------------
// lru_keyed_cache_top: fully associative key-to-handle cache, LRU replacement
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive lookup_key_i and fill_handle_i with start_i high; the
//   transaction is taken at the clock edge where start_i is high and busy_o
//   is low. busy_o stays low, so a request may be issued every cycle.
//   Result: result_valid_o pulses for one cycle with was_hit_o, handle_out_o,
//   did_evict_o and victim_key_o. The receiver cannot stall; it must take
//   the result in that cycle.
//   Path: the request register captures the request, then one lookup pass
//   over it fills the result register that drives the outputs.
//   Throughput: one transaction per cycle. The slot state is written back at
//   the same edge as the result, so the next request sees it.
//   Configuration: cfg_we_i writes cfg_wdata_i into the entry limit
//   (0 acts as 1, values above the slot count act as the slot count). Write
//   it only while no transaction is in flight.
//   Reset: all slots become invalid, occupancy clears, the limit returns to
//   16, and no result is pending. There is no clearing pass.
// ----------------------------------------------------------------------------
module lru_keyed_cache_top
  import lkc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  key_t                lookup_key_i,
  input  handle_t             fill_handle_i,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i,
  output logic                result_valid_o,
  output logic                was_hit_o,
  output handle_t             handle_out_o,
  output logic                did_evict_o,
  output key_t                victim_key_o
);

  localparam logic [CFG_BITS-1:0] LimitReset = CFG_BITS'(16);

  // Request register
  logic    req_vld_q;
  key_t    req_key_q;
  handle_t req_fill_q;

  // Configuration and slot state
  logic [CFG_BITS-1:0] limit_q;
  cnt_t                limit_eff;
  key_t                slot_key_q    [ENTRIES];
  handle_t             slot_handle_q [ENTRIES];
  logic [ENTRIES-1:0]  slot_valid_q, slot_valid_d;
  idx_t                slot_rank_q   [ENTRIES];
  idx_t                slot_rank_d   [ENTRIES];
  cnt_t                occ_q, occ_d;

  // Result register
  logic    res_vld_q;
  logic    res_hit_q;
  handle_t res_handle_q;
  logic    res_evict_q;
  key_t    res_victim_q;

  lookup_t lk;
  logic    do_fill;

  assign busy_o = 1'b0;

  // Capture request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_key_q  <= lookup_key_i;
      req_fill_q <= fill_handle_i;
    end
  end

  // Entry limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Clamp limit into 1..ENTRIES
  always_comb begin
    if (limit_q == '0) begin
      limit_eff = cnt_t'(1);
    end else if (int'(limit_q) > ENTRIES) begin
      limit_eff = cnt_t'(ENTRIES);
    end else begin
      limit_eff = cnt_t'(limit_q);
    end
  end

  lkc_lookup u_lookup (
    .key_i        (req_key_q),
    .slot_key_i   (slot_key_q),
    .slot_valid_i (slot_valid_q),
    .slot_rank_i  (slot_rank_q),
    .occ_i        (occ_q),
    .limit_i      (limit_eff),
    .lookup_o     (lk)
  );

  assign do_fill = req_vld_q && !lk.hit;

  // Next valid flags, age ranks and occupancy
  always_comb begin
    slot_valid_d = slot_valid_q;
    occ_d        = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_rank_d[i] = slot_rank_q[i];
      if (req_vld_q && lk.hit) begin
        if (idx_t'(i) == lk.hit_idx) begin
          slot_rank_d[i] = '0;
        end else if (slot_valid_q[i] && (slot_rank_q[i] < lk.hit_rank)) begin
          slot_rank_d[i] = slot_rank_q[i] + idx_t'(1);
        end
      end else if (do_fill) begin
        if (idx_t'(i) == lk.target_idx) begin
          slot_rank_d[i] = '0;
        end else if (slot_valid_q[i]) begin
          slot_rank_d[i] = slot_rank_q[i] + idx_t'(1);
        end
      end
    end
    if (do_fill) begin
      slot_valid_d[lk.target_idx] = 1'b1;
      if (!lk.evict) begin
        occ_d = occ_q + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      occ_q        <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_rank_q[i] <= '0;
      end
    end else begin
      slot_valid_q <= slot_valid_d;
      occ_q        <= occ_d;
      slot_rank_q  <= slot_rank_d;
    end
  end

  // Write key and handle into the target slot on a miss
  always_ff @(posedge clk_i) begin
    if (do_fill) begin
      slot_key_q[lk.target_idx]    <= req_key_q;
      slot_handle_q[lk.target_idx] <= req_fill_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      res_hit_q    <= lk.hit;
      res_handle_q <= lk.hit ? slot_handle_q[lk.hit_idx] : req_fill_q;
      res_evict_q  <= !lk.hit && lk.evict;
      res_victim_q <= (!lk.hit && lk.evict) ? slot_key_q[lk.target_idx] : '0;
    end
  end

  assign result_valid_o = res_vld_q;
  assign was_hit_o      = res_hit_q;
  assign handle_out_o   = res_handle_q;
  assign did_evict_o    = res_evict_q;
  assign victim_key_o   = res_victim_q;

  // Every accepted transaction returns its result through the request and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 result_valid_o)
    else $error("result strobe missing after accepted transaction");

  // Occupancy tracks the number of valid slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_valid_q) == int'(occ_q))
    else $error("occupancy out of step with valid slots");

  // Occupancy never exceeds the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= ENTRIES)
    else $error("occupancy above slot count");

  // A hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(was_hit_o && did_evict_o))
    else $error("hit reported together with eviction");

endmodule

### tb/sv/tb_lru_keyed_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_keyed_cache_top: self-checking bench for the keyed LRU cache
// Walks a short directed table (extremes, hits, evictions, limit corner
// values), then runs random lookups over several limit settings and sender
// idle mixes. Every transaction is predicted by a behavioral LRU model kept
// in the bench or pinned by its row, and compared field by field with the result.
// ----------------------------------------------------------------------------
module tb_lru_keyed_cache_top;
  import lkc_pkg::*;

  localparam int NUM_ROWS        = 20;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int POOL_SIZE       = 40;
  localparam int QUIET_LIMIT     = 2000;

  typedef struct packed {
    logic    hit;
    handle_t handle;
    logic    evict;
    key_t    victim;
  } lookup_result_t;

  typedef enum logic {ROW_LOOKUP, ROW_LIMIT} row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    key_t           key;
    handle_t        fill;    // carries the limit value on ROW_LIMIT rows
    logic           pinned;  // typed-in result replaces the model's
    lookup_result_t res;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  key_t                lookup_key_i;
  handle_t             fill_handle_i;
  logic                cfg_we_i;
  logic [CFG_BITS-1:0] cfg_wdata_i;
  logic                result_valid_o;
  logic                was_hit_o;
  handle_t             handle_out_o;
  logic                did_evict_o;
  key_t                victim_key_o;

  // Behavioral cache state
  key_t                slot_key_m    [ENTRIES];
  handle_t             slot_handle_m [ENTRIES];
  bit                  slot_valid_m  [ENTRIES];
  int unsigned         slot_rank_m   [ENTRIES];
  int unsigned         fill_count_m;
  logic [CFG_BITS-1:0] limit_m;

  lookup_result_t outstanding_lookups[$];
  lookup_result_t pin_result;
  logic           pin_valid;
  int             mismatches;
  int             quiet_cycles;
  row_t           directed_rows [NUM_ROWS];
  key_t           key_pool [POOL_SIZE];

  lru_keyed_cache_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .lookup_key_i   (lookup_key_i),
    .fill_handle_i  (fill_handle_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .was_hit_o      (was_hit_o),
    .handle_out_o   (handle_out_o),
    .did_evict_o    (did_evict_o),
    .victim_key_o   (victim_key_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Look up one key in the model, update recency and return the outcome
  function automatic lookup_result_t lru_lookup(input key_t key, input handle_t fill);
    lookup_result_t res;
    int             hit_slot;
    int             target;
    int unsigned    cap;
    int unsigned    oldest;
    res      = '0;
    hit_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_slot < 0 && slot_valid_m[i] && slot_key_m[i] == key) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid_m[i] && slot_rank_m[i] < slot_rank_m[hit_slot]) slot_rank_m[i]++;
      end
      slot_rank_m[hit_slot] = 0;
      res.hit    = 1'b1;
      res.handle = slot_handle_m[hit_slot];
      return res;
    end
    // Clamp the limit: zero acts as one, anything above the array acts as full size
    cap = (limit_m == 0) ? 1 : (limit_m > ENTRIES) ? ENTRIES : limit_m;
    target = -1;
    if (fill_count_m < cap) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (target < 0 && !slot_valid_m[i]) target = i;
      end
    end
    if (target < 0) begin
      // Replace the oldest valid slot, first one on a tie
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid_m[i] && (target < 0 || slot_rank_m[i] > oldest)) begin
          target = i;
          oldest = slot_rank_m[i];
        end
      end
      if (target < 0) target = 0;
      if (slot_valid_m[target]) begin
        res.evict            = 1'b1;
        res.victim           = slot_key_m[target];
        slot_valid_m[target] = 1'b0;
        if (fill_count_m > 0) fill_count_m--;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid_m[i]) slot_rank_m[i]++;
    end
    slot_valid_m[target]  = 1'b1;
    slot_key_m[target]    = key;
    slot_handle_m[target] = fill;
    slot_rank_m[target]   = 0;
    fill_count_m++;
    res.handle = fill;
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] seen);
    if (seen !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
    end
  endtask

  // Check results, track limit writes, predict accepted lookups, watch for hangs
  always @(posedge clk_i) begin
    lookup_result_t want;
    lookup_result_t pred;
    logic           moved;
    moved = 1'b0;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key_m[i]    = '0;
        slot_handle_m[i] = '0;
        slot_valid_m[i]  = 1'b0;
        slot_rank_m[i]   = 0;
      end
      fill_count_m = 0;
      limit_m      = CFG_BITS'(16);
      quiet_cycles = 0;
    end else begin
      if (result_valid_o) begin
        moved = 1'b1;
        if (outstanding_lookups.size() == 0) begin
          mismatches++;
          $display("%0t: result with no transaction outstanding, hit %b handle %h",
                   $time, was_hit_o, handle_out_o);
        end else begin
          want = outstanding_lookups[0];
          outstanding_lookups.delete(0);
          compare_field("was_hit",    64'(want.hit),    64'(was_hit_o));
          compare_field("handle_out", 64'(want.handle), 64'(handle_out_o));
          compare_field("did_evict",  64'(want.evict),  64'(did_evict_o));
          compare_field("victim_key", 64'(want.victim), 64'(victim_key_o));
        end
      end
      if (cfg_we_i) limit_m = cfg_wdata_i;
      if (start_i && !busy_o) begin
        moved = 1'b1;
        pred  = lru_lookup(lookup_key_i, fill_handle_i);
        outstanding_lookups.push_back(pin_valid ? pin_result : pred);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Present one lookup and hold it until the cache takes it
  task automatic drive_lookup(input key_t key, input handle_t fill, input logic pinned,
                              input lookup_result_t pinned_res);
    @(negedge clk_i);
    start_i       <= 1'b1;
    lookup_key_i  <= key;
    fill_handle_i <= fill;
    pin_valid  = pinned;
    pin_result = pinned_res;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Stop issuing and wait until every result is back
  task automatic wait_drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (outstanding_lookups.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [CFG_BITS-1:0] limit_plan [NUM_PHASES];
    int                  span_plan  [NUM_PHASES];
    int                  idle_plan  [4];
    int                  idle_pct;
    int                  drain_at;
    key_t                key;

    start_i       = 1'b0;
    lookup_key_i  = '0;
    fill_handle_i = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    pin_valid     = 1'b0;
    pin_result    = '0;
    mismatches    = 0;
    rst_ni        = 1'b0;

    directed_rows = '{
      '{ROW_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 1'b0, 32'h0}},
      '{ROW_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0}},
      '{ROW_LOOKUP, 32'h0000_0000, 32'h1234_5678, 1'b1, '{1'b1, 32'h0000_0000, 1'b0, 32'h0}},
      '{ROW_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
      '{ROW_LOOKUP, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, '{1'b0, 32'h5A5A_5A5A, 1'b0, 32'h0}},
      '{ROW_LIMIT,  32'h0, 32'd0,  1'b0, '0},
      '{ROW_LOOKUP, 32'h1, 32'h11, 1'b0, '0},
      '{ROW_LOOKUP, 32'h2, 32'h22, 1'b0, '0},
      '{ROW_LOOKUP, 32'h1, 32'h0,  1'b0, '0},
      '{ROW_LOOKUP, 32'h3, 32'h33, 1'b0, '0},
      '{ROW_LIMIT,  32'h0, 32'd31, 1'b0, '0},
      '{ROW_LOOKUP, 32'h4, 32'h44, 1'b0, '0},
      '{ROW_LOOKUP, 32'h5, 32'h55, 1'b0, '0},
      '{ROW_LIMIT,  32'h0, 32'd17, 1'b0, '0},
      '{ROW_LOOKUP, 32'h6, 32'h66, 1'b0, '0},
      '{ROW_LIMIT,  32'h0, 32'd1,  1'b0, '0},
      '{ROW_LOOKUP, 32'h7, 32'h77, 1'b0, '0},
      '{ROW_LOOKUP, 32'h2, 32'h0,  1'b0, '0},
      '{ROW_LIMIT,  32'h0, 32'd16, 1'b0, '0},
      '{ROW_LOOKUP, 32'h8, 32'h88, 1'b0, '0}
    };
    limit_plan = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd9, 5'd17, 5'd0};
    span_plan  = '{20, 7, 3, 24, 2, 12, 20, 12};
    idle_plan  = '{0, 54, 0, 17};
    limit_plan[NUM_PHASES-1] = CFG_BITS'($urandom_range(31, 0));

    // Keep the extreme keys in the pool so they keep coming back
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, back to back
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_LIMIT) begin
        wait_drain();
        write_limit(directed_rows[r].fill[CFG_BITS-1:0]);
      end else begin
        drive_lookup(directed_rows[r].key, directed_rows[r].fill,
                     directed_rows[r].pinned, directed_rows[r].res);
      end
    end

    // Random phases: mostly recurring keys so hits, refreshes and evictions mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      write_limit(limit_plan[p]);
      idle_pct = idle_plan[p % 4];
      drain_at = $urandom_range(ITEMS_PER_PHASE - 20, 20);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        while ($urandom_range(99, 0) < idle_pct) begin
          @(negedge clk_i);
          start_i <= 1'b0;
        end
        if (n == drain_at) wait_drain();
        if ($urandom_range(99, 0) < 75) key = key_pool[$urandom_range(span_plan[p] - 1, 0)];
        else key = $urandom();
        drive_lookup(key, $urandom(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (outstanding_lookups.size() != 0) begin
      mismatches++;
      $display("%0t: %0d transactions never returned a result", $time,
               outstanding_lookups.size());
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
hdl/lkc_pkg.sv
hdl/lkc_lookup.sv
hdl/lru_keyed_cache_top.sv
tb/sv/tb_lru_keyed_cache_top.sv
